// File: design/lwtp_pkg.sv
// ----------------------------------------------------------------------------
// lwtp_pkg - shared types and constants for the least-weight thread picker
// Widths, register and action codes, sequencer states and interface structs.
// ----------------------------------------------------------------------------
package lwtp_pkg;

	// thread table size
	localparam int NUM_THREADS = 8;
	localparam int ADDR_W      = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

	// field widths
	localparam int WEIGHT_W   = 32;
	localparam int CHANGE_W   = 17;
	localparam int THREAD_W   = 3;
	localparam int MASK_W     = 8;
	localparam int MASK_IDX_W = 3;
	localparam int COUNT_W    = 4;

	// longest scan: bounded by the table and by the enable mask
	localparam int SCAN_MAX = (NUM_THREADS < MASK_W) ? NUM_THREADS : MASK_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THREAD_COUNT = 1'd1;
	localparam logic [MASK_W-1:0]    MASK_RESET       = 8'hFF;
	localparam logic [COUNT_W-1:0]   COUNT_RESET      = 4'd8;

	// action codes
	localparam logic ACT_ADJUST = 1'b0;
	localparam logic ACT_PICK   = 1'b1;

	// a weight of all ones can never be picked
	localparam logic [WEIGHT_W-1:0] NO_WEIGHT = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADJ,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MASK_W-1:0]  enabled_mask;
		logic [COUNT_W-1:0] thread_count;
	} cfg_t;

	typedef struct packed {
		logic                found;
		logic [THREAD_W-1:0] chosen_thread;
		logic [WEIGHT_W-1:0] weight_now;
	} res_t;

endpackage

// File: design/least_weight_thread_picker_unit.sv
// ----------------------------------------------------------------------------
// least_weight_thread_picker_unit - least-loaded thread picker
// Adjust: item accepted, weight read, then written back and registered as the result.
// Pick: one RAM read per scanned thread, then a drain step (skipped when
// nothing is scanned); one item in flight at a time.
// Reset clears the config to all enabled, eight threads, and every weight
// reads as zero until first written. Results wait in an output register.
// ----------------------------------------------------------------------------
module least_weight_thread_picker_unit import lwtp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       wr_en,
	input  logic [CFG_IDX_W-1:0]       wr_index,
	input  logic [CFG_DATA_W-1:0]      wr_data,
	// input items
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [THREAD_W-1:0]        thread_index,
	input  logic signed [CHANGE_W-1:0] weight_change,
	// result items
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [THREAD_W-1:0]        chosen_thread,
	output logic [WEIGHT_W-1:0]        weight_now
);

	cfg_t cfg_q;
	res_t eng_res;
	res_t out_res_q;
	logic eng_res_valid;
	logic res_take;
	logic out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled_mask <= MASK_RESET;
			cfg_q.thread_count <= COUNT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ENABLED_MASK: cfg_q.enabled_mask <= wr_data[MASK_W-1:0];
				REG_THREAD_COUNT: cfg_q.thread_count <= wr_data[COUNT_W-1:0];
				default:          ;
			endcase
		end
	end

	lwtp_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.thread_index  (thread_index),
		.weight_change (weight_change),
		.res_valid     (eng_res_valid),
		.res           (eng_res),
		.res_take      (res_take)
	);

	// output register: loads whenever it is empty or being drained
	assign res_take = eng_res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= eng_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = out_res_q.found;
	assign chosen_thread = out_res_q.chosen_thread;
	assign weight_now    = out_res_q.weight_now;

	// an accepted item keeps the input side busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again straight after an accepted item");

	// a pending engine result means the input side is closed
	assert property (@(posedge clk) disable iff (!arst_n)
		eng_res_valid |-> in_stall)
		else $error("input open while a result is pending");

	// nothing found always reports a zero weight
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> weight_now == '0)
		else $error("weight reported with no thread found");

endmodule

// File: design/lwtp_ram.sv
// ----------------------------------------------------------------------------
// lwtp_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module lwtp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/lwtp_engine.sv
// ----------------------------------------------------------------------------
// lwtp_engine - weight table sequencer
// Holds the weight RAM with per-entry valid bits, runs read-modify-write for
// adjust items and a one-entry-per-cycle compare scan for pick items.
// ----------------------------------------------------------------------------
module lwtp_engine import lwtp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [THREAD_W-1:0]        thread_index,
	input  logic signed [CHANGE_W-1:0] weight_change,
	output logic                       res_valid,
	output res_t                       res,
	input  logic                       res_take
);

	state_t state_q, state_d;

	// RAM port signals
	logic                ram_wr_en;
	logic [ADDR_W-1:0]   ram_wr_addr;
	logic [WEIGHT_W-1:0] ram_wr_data;
	logic                ram_rd_en;
	logic [ADDR_W-1:0]   ram_rd_addr;
	logic [WEIGHT_W-1:0] ram_rd_data;

	// entry valid bits: an unwritten entry reads as zero
	logic [NUM_THREADS-1:0] wvld_q;

	// item registers
	logic                       in_range_q;
	logic [THREAD_W-1:0]        adj_idx_q;
	logic [CHANGE_W-1:0]        change_q;
	logic [ADDR_W-1:0]          cnt_q;

	// read stage
	logic                rd_vld_s1;
	logic                cmp_v_s1;
	logic [ADDR_W-1:0]   rd_idx_s1;

	// result registers
	logic [WEIGHT_W-1:0] best_q;
	logic [THREAD_W-1:0] pick_q;
	logic                hit_q;

	logic                accept;
	logic                in_range;
	logic [COUNT_W-1:0]  limit;
	logic [ADDR_W-1:0]   last_idx;
	logic [WEIGHT_W-1:0] old_weight;
	logic [WEIGHT_W-1:0] sum_weight;
	logic                better;

	lwtp_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (NUM_THREADS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_range = (32'(thread_index) < NUM_THREADS);

	// scan length, saturated to the table and mask size
	assign limit    = (cfg.thread_count > COUNT_W'(SCAN_MAX)) ? COUNT_W'(SCAN_MAX)
	                                                          : cfg.thread_count;
	assign last_idx = ADDR_W'(limit - COUNT_W'(1));

	// weight read back this cycle
	assign old_weight = rd_vld_s1 ? ram_rd_data : '0;
	assign sum_weight = old_weight
	                  + {{(WEIGHT_W-CHANGE_W){change_q[CHANGE_W-1]}}, change_q};

	// strict less-than keeps the lowest index on ties
	assign better = cmp_v_s1 && cfg.enabled_mask[MASK_IDX_W'(rd_idx_s1)]
	                && (old_weight < best_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_ADJUST) begin
						state_d = ST_ADJ;
					end else if (limit == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_ADJ:   state_d = ST_DONE;
			ST_SCAN: begin
				if (cnt_q == last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and RAM controls
	always_comb begin
		in_stall    = 1'b1;
		res_valid   = 1'b0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = cnt_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = ADDR_W'(adj_idx_q);
		ram_wr_data = sum_weight;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				ram_rd_en   = accept && (action == ACT_ADJUST);
				ram_rd_addr = ADDR_W'(thread_index);
			end
			ST_ADJ:   ram_wr_en = in_range_q;
			ST_SCAN:  ram_rd_en = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  res_valid = 1'b1;
			default:  ;
		endcase
	end

	assign res.found         = hit_q;
	assign res.chosen_thread = pick_q;
	assign res.weight_now    = hit_q ? best_q : '0;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wvld_q    <= '0;
			cmp_v_s1  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= (state_q == ST_SCAN);
			if (ram_wr_en) begin
				wvld_q[ram_wr_addr] <= 1'b1;
			end
		end
	end

	// read stage and item registers
	always_ff @(posedge clk) begin
		if (ram_rd_en) begin
			rd_vld_s1 <= wvld_q[ram_rd_addr];
			rd_idx_s1 <= ram_rd_addr;
		end
		if (accept) begin
			in_range_q <= in_range;
			adj_idx_q  <= thread_index;
			change_q   <= weight_change;
		end
		if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + ADDR_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			best_q <= NO_WEIGHT;
			pick_q <= '0;
			hit_q  <= 1'b0;
		end else if (state_q == ST_ADJ) begin
			best_q <= in_range_q ? sum_weight : '0;
			pick_q <= adj_idx_q;
			hit_q  <= in_range_q;
		end else if (better) begin
			best_q <= old_weight;
			pick_q <= THREAD_W'(rd_idx_s1);
			hit_q  <= 1'b1;
		end
	end

endmodule

// File: tb/sv/tb_least_weight_thread_picker_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_least_weight_thread_picker_unit - self-checking bench for the thread picker
// Walks a short table of directed items and register writes, then runs
// phases of random adjusts and picks under several mask and count settings.
// Every result is checked against an in-bench model of the load table or a typed expectation.
// ----------------------------------------------------------------------------
module tb_least_weight_thread_picker_unit;
	import lwtp_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 120;
	localparam int PLAN_LEN    = 29;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic                   act;
		logic [THREAD_W-1:0]    idx;
		logic [CHANGE_W-1:0]    chg;
		logic [CFG_IDX_W-1:0]   reg_sel;
		logic [CFG_DATA_W-1:0]  reg_val;
		logic                   typed;
		res_t                   want;
	} plan_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       wr_en;
	logic [CFG_IDX_W-1:0]       wr_index;
	logic [CFG_DATA_W-1:0]      wr_data;
	logic                       in_valid;
	logic                       in_stall;
	logic                       action;
	logic [THREAD_W-1:0]        thread_index;
	logic signed [CHANGE_W-1:0] weight_change;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       found;
	logic [THREAD_W-1:0]        chosen_thread;
	logic [WEIGHT_W-1:0]        weight_now;

	// bench copy of the load table and registers
	logic [WEIGHT_W-1:0] load_now [NUM_THREADS];
	logic [MASK_W-1:0]   cfg_mask;
	logic [COUNT_W-1:0]  cfg_count;
	res_t                results_due [$];

	// values seen just before each rising edge
	logic in_take = 1'b0;
	logic out_take = 1'b0;
	res_t got;
	res_t due;

	logic calm;
	int   errors = 0;
	int   cycles = 0;
	int   n_adjust;
	int   n_pick;
	int   n_none = 0;
	int   n_writes;

	// directed table: a typed expectation only where it is obvious
	plan_row_t plan [PLAN_LEN] = '{
		'{ROW_ITEM, ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h00, 1'b1,
			'{1'b1, 3'd0, 32'h0}},
		'{ROW_ITEM, ACT_ADJUST, 3'd0, 17'h0FFFF, REG_ENABLED_MASK, 8'h00, 1'b1,
			'{1'b1, 3'd0, 32'h0000FFFF}},
		'{ROW_ITEM, ACT_ADJUST, 3'd1, 17'h10000, REG_ENABLED_MASK, 8'h00, 1'b1,
			'{1'b1, 3'd1, 32'hFFFF0000}},
		'{ROW_ITEM, ACT_ADJUST, 3'd2, 17'h1FFFF, REG_ENABLED_MASK, 8'h00, 1'b1,
			'{1'b1, 3'd2, 32'hFFFFFFFF}},
		'{ROW_ITEM, ACT_ADJUST, 3'd7, 17'h18000, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		'{ROW_ITEM, ACT_ADJUST, 3'd3, 17'h00001, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		'{ROW_ITEM, ACT_ADJUST, 3'd4, 17'h05555, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		'{ROW_ITEM, ACT_ADJUST, 3'd5, 17'h0AAAA, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		'{ROW_ITEM, ACT_ADJUST, 3'd6, 17'h15555, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		'{ROW_ITEM, ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		// wrap from all ones back to zero and out again
		'{ROW_ITEM, ACT_ADJUST, 3'd2, 17'h00001, REG_ENABLED_MASK, 8'h00, 1'b1,
			'{1'b1, 3'd2, 32'h0}},
		'{ROW_ITEM, ACT_ADJUST, 3'd2, 17'h1FFFF, REG_ENABLED_MASK, 8'h00, 1'b1,
			'{1'b1, 3'd2, 32'hFFFFFFFF}},
		// only an all-ones weight enabled: nothing can be picked
		'{ROW_CFG,  ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h04, 1'b0, '0},
		'{ROW_ITEM, ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h00, 1'b1, '0},
		'{ROW_CFG,  ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		'{ROW_ITEM, ACT_PICK,   3'd5, 17'h0FFFF, REG_ENABLED_MASK, 8'h00, 1'b1, '0},
		'{ROW_CFG,  ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'hFF, 1'b0, '0},
		// zero threads scanned, then a count past the table
		'{ROW_CFG,  ACT_PICK,   3'd0, 17'h00000, REG_THREAD_COUNT, 8'h00, 1'b0, '0},
		'{ROW_ITEM, ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h00, 1'b1, '0},
		'{ROW_CFG,  ACT_PICK,   3'd0, 17'h00000, REG_THREAD_COUNT, 8'h0F, 1'b0, '0},
		'{ROW_ITEM, ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		'{ROW_CFG,  ACT_PICK,   3'd0, 17'h00000, REG_THREAD_COUNT, 8'h01, 1'b0, '0},
		'{ROW_ITEM, ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h00, 1'b1,
			'{1'b1, 3'd0, 32'h0000FFFF}},
		'{ROW_CFG,  ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h80, 1'b0, '0},
		'{ROW_CFG,  ACT_PICK,   3'd0, 17'h00000, REG_THREAD_COUNT, 8'h08, 1'b0, '0},
		'{ROW_ITEM, ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		'{ROW_ITEM, ACT_PICK,   3'd7, 17'h1FFFF, REG_ENABLED_MASK, 8'h00, 1'b0, '0},
		'{ROW_CFG,  ACT_PICK,   3'd0, 17'h00000, REG_ENABLED_MASK, 8'hFF, 1'b0, '0},
		'{ROW_ITEM, ACT_ADJUST, 3'd0, 17'h1FFFF, REG_ENABLED_MASK, 8'h00, 1'b0, '0}
	};

	least_weight_thread_picker_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.thread_index  (thread_index),
		.weight_change (weight_change),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.chosen_thread (chosen_thread),
		.weight_now    (weight_now)
	);

	// clock, 10 ns
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// outputs settle well before the falling edge; take them there
	always @(negedge clk) begin
		in_take  = in_valid && !in_stall;
		out_take = out_valid && !out_stall;
		got      = '{found, chosen_thread, weight_now};
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 27);
	end

	// model: adjust adds the sign-extended change, pick finds the strict minimum
	function automatic res_t picker_result(input logic act, input logic [THREAD_W-1:0] idx,
		input logic [CHANGE_W-1:0] chg);
		res_t              r;
		logic [WEIGHT_W-1:0] best;
		int                scan;
		int                i;
		r    = '0;
		best = NO_WEIGHT;
		scan = (int'(cfg_count) > SCAN_MAX) ? SCAN_MAX : int'(cfg_count);
		if (act == ACT_ADJUST) begin
			load_now[idx] = load_now[idx] + {{(WEIGHT_W-CHANGE_W){chg[CHANGE_W-1]}}, chg};
			r = '{1'b1, idx, load_now[idx]};
		end else begin
			for (i = 0; i < scan; i++) begin
				if (cfg_mask[i] && load_now[i] < best) begin
					best = load_now[i];
					r    = '{1'b1, THREAD_W'(i), best};
				end
			end
		end
		return r;
	endfunction

	task automatic mismatch(input string what, input logic [31:0] e, input logic [31:0] a);
		$display("%0t: %s mismatch, expected %h, got %h", $time, what, e, a);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_take) begin
			if (results_due.size() == 0) begin
				mismatch("unexpected result, weight", 32'h0, got.weight_now);
			end else begin
				due = results_due.pop_front();
				if (got.found !== due.found)
					mismatch("found", 32'(due.found), 32'(got.found));
				if (got.chosen_thread !== due.chosen_thread)
					mismatch("chosen_thread", 32'(due.chosen_thread),
						32'(got.chosen_thread));
				if (got.weight_now !== due.weight_now)
					mismatch("weight_now", due.weight_now, got.weight_now);
				if (got.found === 1'b0)
					n_none++;
			end
		end
	end

	// one item: optional idle gap, then hold until taken
	task automatic send_item(input logic act, input logic [THREAD_W-1:0] idx,
		input logic [CHANGE_W-1:0] chg, input logic typed, input res_t want);
		res_t r;
		if (!calm && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 27)
				@(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		thread_index  <= idx;
		weight_change <= chg;
		@(posedge clk);
		while (!in_take)
			@(posedge clk);
		r = picker_result(act, idx, chg);
		results_due.push_back(typed ? want : r);
		if (act == ACT_ADJUST)
			n_adjust++;
		else
			n_pick++;
	endtask

	// register write once the block has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
		input logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= sel;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (sel == REG_ENABLED_MASK)
			cfg_mask = val[MASK_W-1:0];
		else
			cfg_count = val[COUNT_W-1:0];
		n_writes++;
	endtask

	// stimulus
	initial begin
		int               k;
		int               ph;
		int               n;
		logic             act;
		logic [THREAD_W-1:0] idx;
		logic [CHANGE_W-1:0] chg;
		logic [MASK_W-1:0]   m;
		logic [COUNT_W-1:0]  c;
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = REG_ENABLED_MASK;
		wr_data       = '0;
		in_valid      = 1'b0;
		action        = ACT_ADJUST;
		thread_index  = '0;
		weight_change = '0;
		calm          = 1'b0;
		n_adjust      = 0;
		n_pick        = 0;
		n_writes      = 0;
		cfg_mask      = MASK_RESET;
		cfg_count     = COUNT_RESET;
		for (k = 0; k < NUM_THREADS; k++)
			load_now[k] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (k = 0; k < PLAN_LEN; k++) begin
			if (plan[k].kind == ROW_CFG)
				write_reg(plan[k].reg_sel, plan[k].reg_val);
			else
				send_item(plan[k].act, plan[k].idx, plan[k].chg, plan[k].typed,
					plan[k].want);
		end

		// random phases, each under its own register setting
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					m = 8'hFF;
					c = 4'd8;
				end
				1: begin
					m = 8'h00;
					c = 4'd8;
				end
				2: begin
					m = 8'hFF;
					c = 4'd0;
				end
				3: begin
					m = MASK_W'($urandom);
					c = 4'd15;
				end
				PHASES - 1: begin
					m = 8'h01;
					c = 4'd1;
				end
				default: begin
					m = MASK_W'($urandom);
					c = COUNT_W'($urandom_range(15));
				end
			endcase
			write_reg(REG_ENABLED_MASK, m);
			// upper bits of a count write are junk and must be ignored
			write_reg(REG_THREAD_COUNT, {4'($urandom_range(15)), c});
			calm = (ph == 6 || ph == 7);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				act = ($urandom_range(99) < 50) ? ACT_PICK : ACT_ADJUST;
				idx = THREAD_W'($urandom_range(NUM_THREADS - 1));
				// small steps keep weights close so ties and wraps are common
				case ($urandom_range(9))
					0: chg = 17'h10000;
					1: chg = 17'h0FFFF;
					2, 3: chg = CHANGE_W'($urandom);
					default: chg = CHANGE_W'($urandom_range(6) - 3);
				endcase
				send_item(act, idx, chg, 1'b0, '0);
			end
		end
		calm = 1'b0;

		// drain and let the block settle
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d adjusts and %0d picks across %0d register writes;", n_adjust, n_pick,
			n_writes);
		$display("%0d results reported no thread, %0d mismatches seen.", n_none, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
design/lwtp_pkg.sv
design/lwtp_ram.sv
design/lwtp_engine.sv
design/least_weight_thread_picker_unit.sv
tb/sv/tb_least_weight_thread_picker_unit.sv
